// ----- rtl/ffba_pkg.sv -----
`default_nettype none

package ffba_pkg;

	// Fixed field widths of the request and result transactions.
	localparam int ACT_W  = 2;
	localparam int REQ_W  = 12;
	localparam int ADDR_W = 11;
	localparam int STAT_W = 2;
	localparam int COPY_W = 12;

	// Action codes.
	localparam logic [ACT_W-1:0] ACT_ALLOC  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FREE   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_RESIZE = 2'd2;

	// Status codes.
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BADADDR = 2'd2;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [REQ_W-1:0]  request_size;
		logic [ADDR_W-1:0] payload_address;
	} item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] result_address;
		logic [STAT_W-1:0] status;
		logic              moved;
		logic [COPY_W-1:0] copy_length;
	} res_t;

	// Sequencer states, one-hot.
	typedef enum logic [22:0] {
		ST_CLEAR   = 23'd1 << 0,
		ST_IDLE    = 23'd1 << 1,
		ST_DEC     = 23'd1 << 2,
		ST_LOC_EV  = 23'd1 << 3,
		ST_RZ_NX   = 23'd1 << 4,
		ST_RZ_DEC  = 23'd1 << 5,
		ST_PV_RD   = 23'd1 << 6,
		ST_PV_EV   = 23'd1 << 7,
		ST_PV_DEC  = 23'd1 << 8,
		ST_PV_CMP  = 23'd1 << 9,
		ST_FF_RD   = 23'd1 << 10,
		ST_FF_EV   = 23'd1 << 11,
		ST_FF_NX   = 23'd1 << 12,
		ST_K1      = 23'd1 << 13,
		ST_K2      = 23'd1 << 14,
		ST_CLR_OLD = 23'd1 << 15,
		ST_C_RD    = 23'd1 << 16,
		ST_C_EV    = 23'd1 << 17,
		ST_C_CHK   = 23'd1 << 18,
		ST_C_NX    = 23'd1 << 19,
		ST_C_ZN    = 23'd1 << 20,
		ST_DONE    = 23'd1 << 21,
		ST_SPARE   = 23'd1 << 22
	} state_t;

	// Which path a carve belongs to.
	typedef enum logic [1:0] {
		MD_ALLOC   = 2'd0,
		MD_INPLACE = 2'd1,
		MD_PREV    = 2'd2,
		MD_FF      = 2'd3
	} mode_t;

endpackage

`default_nettype wire

// ----- rtl/ffba_ram.sv -----
`default_nettype none

module ffba_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/ffba_alu.sv -----
`default_nettype none

module ffba_alu #(
	parameter int W = 13
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	output logic      [W-1:0] sum,
	output logic      [W-1:0] diff,
	output logic              ge
);

	logic [W:0] sub_full;

	// One adder and one subtractor; the borrow gives the compare.
	always_comb begin
		sum      = a + b;
		sub_full = {1'b0, a} - {1'b0, b};
		diff     = sub_full[W-1:0];
		ge       = ~sub_full[W];
	end

endmodule

`default_nettype wire

// ----- rtl/ffba_ctrl.sv -----
`default_nettype none

module ffba_ctrl #(
	parameter int POOL_UNITS   = 2048,
	parameter int HEADER_UNITS = 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	input  wire ffba_pkg::item_t item,
	output logic                item_ready,
	output logic                res_valid,
	output ffba_pkg::res_t      res,
	input  wire logic           res_ready
);
	import ffba_pkg::*;

	localparam int PW = $clog2(POOL_UNITS);
	localparam int SW = $clog2(POOL_UNITS + 1);
	localparam int VW = ((SW > REQ_W) ? SW : REQ_W) + 1;
	localparam int EW = SW + 1;
	localparam logic [VW-1:0] POOL_V   = VW'(POOL_UNITS);
	localparam logic [VW-1:0] HDR_V    = VW'(HEADER_UNITS);
	localparam logic [PW-1:0] LAST_IDX = PW'(POOL_UNITS - 1);

	state_t          state_q;
	mode_t           mode_q;
	item_t           item_q;
	res_t            res_q;
	logic [PW-1:0]   clr_q;
	logic [VW-1:0]   need_q, s_q, old_q, n_q, avail_q, w_q;
	logic [VW-1:0]   cur_sz_q, prev_q, prev_sz_q, ktotal_q, kpos_q, diff_q;
	logic            cur_used_q, prev_used_q, prev_ok_q;

	logic            ram_we;
	logic [PW-1:0]   ram_waddr, ram_raddr;
	logic [EW-1:0]   ram_wdata, ram_rdata;
	logic [VW-1:0]   alu_a, alu_b, alu_sum, alu_diff;
	logic            alu_ge;

	logic [VW-1:0]   rd_size, loc_p, addr_v;
	logic            rd_used, split, merge;

	ffba_ram #(.WIDTH(EW), .DEPTH(POOL_UNITS)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ffba_alu #(.W(VW)) u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sum (alu_sum),
		.diff(alu_diff),
		.ge  (alu_ge)
	);

	// A table word is {used, size}; a nonzero size marks a block start.
	assign rd_used    = ram_rdata[SW];
	assign rd_size    = VW'(ram_rdata[SW-1:0]);
	assign addr_v     = VW'(item_q.payload_address);
	assign loc_p      = addr_v - HDR_V;
	assign split      = alu_diff > HDR_V;
	assign merge      = ~cur_used_q & ~rd_used;
	assign item_ready = (state_q == ST_IDLE);
	assign res_valid  = (state_q == ST_DONE);
	assign res        = res_q;

	// Memory port and shared adder operands for each step.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		alu_a     = '0;
		alu_b     = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = (clr_q == '0) ? {1'b0, SW'(POOL_UNITS)} : '0;
			end
			ST_DEC: begin
				ram_raddr = loc_p[PW-1:0];
			end
			ST_LOC_EV: begin
				alu_a     = s_q;
				alu_b     = rd_size;
				ram_raddr = alu_sum[PW-1:0];
				if (rd_size != '0 && rd_used && item_q.action == ACT_FREE) begin
					ram_we    = 1'b1;
					ram_waddr = s_q[PW-1:0];
					ram_wdata = {1'b0, rd_size[SW-1:0]};
				end
			end
			ST_RZ_NX: begin
				alu_a = old_q;
				alu_b = rd_used ? '0 : rd_size;
			end
			ST_RZ_DEC: begin
				alu_a = avail_q;
				alu_b = need_q;
				if (alu_ge && avail_q != old_q) begin
					ram_we    = 1'b1;
					ram_waddr = n_q[PW-1:0];
				end
			end
			ST_PV_RD, ST_FF_RD, ST_C_RD: begin
				ram_raddr = w_q[PW-1:0];
			end
			ST_PV_EV: begin
				alu_a = w_q;
				alu_b = rd_size;
			end
			ST_PV_DEC: begin
				alu_a = prev_sz_q;
				alu_b = old_q;
			end
			ST_PV_CMP: begin
				alu_a = ktotal_q;
				alu_b = need_q;
				if (prev_ok_q && !prev_used_q && alu_ge) begin
					ram_we    = 1'b1;
					ram_waddr = s_q[PW-1:0];
				end
			end
			ST_FF_EV: begin
				alu_a = rd_size;
				alu_b = need_q;
			end
			ST_FF_NX: begin
				alu_a = w_q;
				alu_b = cur_sz_q;
			end
			ST_K1: begin
				alu_a     = ktotal_q;
				alu_b     = need_q;
				ram_we    = 1'b1;
				ram_waddr = kpos_q[PW-1:0];
				ram_wdata = {1'b1, split ? need_q[SW-1:0] : ktotal_q[SW-1:0]};
			end
			ST_K2: begin
				alu_a     = kpos_q;
				alu_b     = need_q;
				ram_we    = 1'b1;
				ram_waddr = alu_sum[PW-1:0];
				ram_wdata = {1'b0, diff_q[SW-1:0]};
			end
			ST_CLR_OLD: begin
				ram_we    = 1'b1;
				ram_waddr = s_q[PW-1:0];
				ram_wdata = {1'b0, old_q[SW-1:0]};
			end
			ST_C_CHK: begin
				alu_a     = w_q;
				alu_b     = cur_sz_q;
				ram_raddr = alu_sum[PW-1:0];
			end
			ST_C_NX: begin
				alu_a = cur_sz_q;
				alu_b = rd_size;
				if (merge) begin
					ram_we    = 1'b1;
					ram_waddr = w_q[PW-1:0];
					ram_wdata = {1'b0, alu_sum[SW-1:0]};
				end
			end
			ST_C_ZN: begin
				ram_we    = 1'b1;
				ram_waddr = n_q[PW-1:0];
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + PW'(1);
					if (clr_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_valid) begin
						item_q  <= item;
						res_q   <= '0;
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					need_q <= VW'(item_q.request_size) + HDR_V;
					w_q    <= '0;
					case (item_q.action)
						ACT_ALLOC: begin
							mode_q  <= MD_ALLOC;
							state_q <= ST_FF_RD;
						end
						ACT_FREE, ACT_RESIZE: begin
							if (addr_v < HDR_V || loc_p >= POOL_V) begin
								res_q.status <= STAT_BADADDR;
								state_q      <= ST_DONE;
							end else begin
								s_q     <= loc_p;
								state_q <= ST_LOC_EV;
							end
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_LOC_EV: begin
					if (rd_size == '0 || !rd_used) begin
						res_q.status <= STAT_BADADDR;
						state_q      <= ST_DONE;
					end else if (item_q.action == ACT_FREE) begin
						res_q.result_address <= item_q.payload_address;
						w_q     <= '0;
						state_q <= ST_C_RD;
					end else begin
						old_q <= rd_size;
						n_q   <= alu_sum;
						if (alu_sum < POOL_V) begin
							state_q <= ST_RZ_NX;
						end else begin
							avail_q <= rd_size;
							state_q <= ST_RZ_DEC;
						end
					end
				end
				ST_RZ_NX: begin
					avail_q <= alu_sum;
					state_q <= ST_RZ_DEC;
				end
				ST_RZ_DEC: begin
					if (alu_ge) begin
						mode_q   <= MD_INPLACE;
						kpos_q   <= s_q;
						ktotal_q <= avail_q;
						res_q.result_address <= item_q.payload_address;
						state_q  <= ST_K1;
					end else begin
						w_q       <= '0;
						prev_ok_q <= 1'b0;
						state_q   <= ST_PV_RD;
					end
				end
				ST_PV_RD: begin
					state_q <= (w_q == s_q) ? ST_PV_DEC : ST_PV_EV;
				end
				ST_PV_EV: begin
					if (rd_size == '0) begin
						prev_ok_q <= 1'b0;
						w_q       <= '0;
						mode_q    <= MD_FF;
						state_q   <= ST_FF_RD;
					end else begin
						prev_q      <= w_q;
						prev_sz_q   <= rd_size;
						prev_used_q <= rd_used;
						prev_ok_q   <= 1'b1;
						w_q         <= alu_sum;
						state_q     <= ST_PV_RD;
					end
				end
				ST_PV_DEC: begin
					ktotal_q <= alu_sum;
					state_q  <= ST_PV_CMP;
				end
				ST_PV_CMP: begin
					if (prev_ok_q && !prev_used_q && alu_ge) begin
						mode_q  <= MD_PREV;
						kpos_q  <= prev_q;
						res_q.result_address <= ADDR_W'(prev_q + HDR_V);
						res_q.moved          <= 1'b1;
						res_q.copy_length    <= COPY_W'(old_q - HDR_V);
						state_q <= ST_K1;
					end else begin
						w_q     <= '0;
						mode_q  <= MD_FF;
						state_q <= ST_FF_RD;
					end
				end
				ST_FF_RD: begin
					if (w_q >= POOL_V) begin
						res_q.status <= STAT_NOSPACE;
						if (mode_q == MD_FF) begin
							res_q.result_address <= item_q.payload_address;
						end
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_FF_EV;
					end
				end
				ST_FF_EV: begin
					cur_sz_q <= rd_size;
					if (rd_size == '0) begin
						res_q.status <= STAT_NOSPACE;
						if (mode_q == MD_FF) begin
							res_q.result_address <= item_q.payload_address;
						end
						state_q <= ST_DONE;
					end else if (!rd_used && alu_ge) begin
						kpos_q   <= w_q;
						ktotal_q <= rd_size;
						res_q.result_address <= ADDR_W'(w_q + HDR_V);
						if (mode_q == MD_FF) begin
							res_q.moved       <= 1'b1;
							res_q.copy_length <= COPY_W'(old_q - HDR_V);
						end
						state_q <= ST_K1;
					end else begin
						state_q <= ST_FF_NX;
					end
				end
				ST_FF_NX: begin
					w_q     <= alu_sum;
					state_q <= ST_FF_RD;
				end
				ST_K1, ST_K2: begin
					if (state_q == ST_K1) begin
						diff_q <= alu_diff;
					end
					if (state_q == ST_K1 && split) begin
						state_q <= ST_K2;
					end else if (mode_q == MD_ALLOC) begin
						state_q <= ST_DONE;
					end else if (mode_q == MD_FF) begin
						state_q <= ST_CLR_OLD;
					end else begin
						w_q     <= '0;
						state_q <= ST_C_RD;
					end
				end
				ST_CLR_OLD: begin
					w_q     <= '0;
					state_q <= ST_C_RD;
				end
				ST_C_RD: begin
					state_q <= ST_C_EV;
				end
				ST_C_EV: begin
					cur_sz_q   <= rd_size;
					cur_used_q <= rd_used;
					state_q    <= ST_C_CHK;
				end
				ST_C_CHK: begin
					if (cur_sz_q == '0 || alu_sum >= POOL_V) begin
						state_q <= ST_DONE;
					end else begin
						n_q     <= alu_sum;
						state_q <= ST_C_NX;
					end
				end
				ST_C_NX: begin
					if (merge) begin
						cur_sz_q <= alu_sum;
						state_q  <= ST_C_ZN;
					end else begin
						w_q        <= n_q;
						cur_sz_q   <= rd_size;
						cur_used_q <= rd_used;
						state_q    <= ST_C_CHK;
					end
				end
				ST_C_ZN: begin
					state_q <= ST_C_CHK;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/first_fit_block_allocator_top.sv -----
`default_nettype none

// Channel   Direction  Signals                      Contents
// request   in         s_tvalid s_tready s_tuser    tuser: action
//                      s_tdata                      tdata: request_size, payload_address
// result    out        m_tvalid m_tready m_tdata    tdata: result_address, status, moved,
//                                                   copy_length
//
// One request transaction is handled at a time; s_tready is low while it is worked.
// Every chain step waits on the registered read of the block table. The first-fit walk
// reads, evaluates and steps past each block it passes over; the walk to the previous
// block reads and evaluates each block. An allocate writes the carved header and, when
// the block is split, the header of the remainder; free and resize add a coalescing walk
// that checks each block and merges a free block into the free block before it.
// After reset the table is cleared, unit by unit, before s_tready rises.
// The result sits in an output register, so the next request is taken while it waits.

module first_fit_block_allocator_top #(
	parameter int POOL_UNITS   = 2048,
	parameter int HEADER_UNITS = 1
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [1:0]  s_tuser,   // action
	input  wire logic [23:0] s_tdata,   // request_size[11:0], payload_address[22:12]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata    // result_address[10:0], status[12:11],
	                                    // moved[13], copy_length[25:14]
);
	import ffba_pkg::*;

	item_t item;
	res_t  res, out_q;
	logic  res_valid, res_ready, item_ready;

	assign item.action          = s_tuser;
	assign item.request_size    = s_tdata[11:0];
	assign item.payload_address = s_tdata[22:12];
	assign s_tready             = item_ready;

	ffba_ctrl #(.POOL_UNITS(POOL_UNITS), .HEADER_UNITS(HEADER_UNITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(s_tvalid),
		.item      (item),
		.item_ready(item_ready),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// Output register between the sequencer and the result channel.
	assign res_ready = ~m_tvalid | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (res_ready) begin
			m_tvalid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tdata = {6'd0, out_q.copy_length, out_q.moved, out_q.status,
		out_q.result_address};

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while a transaction is still in work");

	a_result_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !item_ready)
		else $error("result pending while the sequencer reports idle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_q.status == STAT_OK || out_q.status == STAT_NOSPACE ||
		out_q.status == STAT_BADADDR))
		else $error("undefined status on result");

	a_moved_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.moved) |-> (out_q.status == STAT_OK))
		else $error("moved result without ok status");
`endif

endmodule

`default_nettype wire
